FILE: hw/rtl/rope_pkg.sv
// Package: shared types, constants and elaboration-time tables for the RoPE block.
package rope_pkg;

  localparam int MAX_PAIRS      = 4096;
  localparam int POSITION_WIDTH = 24;
  localparam int CORDIC_STAGES  = 24;
  localparam int FRAC_BITS      = 24;
  localparam int IDX_W          = 12;
  localparam int PCNT_W         = 13;
  localparam int STEP_W         = 32;
  localparam int E_W            = IDX_W + STEP_W;
  localparam int CS_W           = 34;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'h28BE60DC;
  localparam longint unsigned Q60_ONE = 64'd1 << 60;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_INDEX = 2'd1,
    ERR_POS   = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    REG_PAIR_COUNT = 2'd0,
    REG_EXP_STEP   = 2'd1,
    REG_POS_OFFSET = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [PCNT_W-1:0]         pair_count;
    logic [STEP_W-1:0]         exponent_step;
    logic [POSITION_WIDTH-1:0] pos_base;
  } cfg_t;

  // data that rides along the pipeline untouched
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    err_t               err;
    logic               last;
  } side_t;

  function automatic longint unsigned isqrt64(input longint unsigned v_in);
    longint unsigned v, res, bit_w;
    v = v_in;
    res = 0;
    bit_w = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (bit_w > v) bit_w = bit_w >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (bit_w != 0) begin
        if (v >= res + bit_w) begin
          v = v - (res + bit_w);
          res = (res >> 1) + bit_w;
        end else begin
          res = res >> 1;
        end
        bit_w = bit_w >> 2;
      end
    end
    return res;
  endfunction

  // floor quotient by shift and subtract, used only for table constants
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    logic [64:0]     rem;
    longint unsigned quo;
    rem = '0;
    quo = 0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], num[k]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[k] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [31:0] root_q32(input int j);
    longint unsigned r;
    r = isqrt64(64'd1 << 63);
    for (int k = 2; k <= FRAC_BITS; k++) begin
      if (k <= j) r = isqrt64({r[31:0], 32'd0});
    end
    return r[31:0];
  endfunction

  function automatic longint unsigned atan_recip_q60(input longint unsigned n);
    longint unsigned p, nsq, sum, t;
    bit done;
    p = n;
    nsq = n * n;
    sum = 0;
    done = 1'b0;
    for (int k = 0; k < 40; k++) begin
      if (!done && p <= Q60_ONE) begin
        t = udiv64(udiv64(Q60_ONE, p), longint'(2 * k + 1));
        if (k[0]) sum = sum - t;
        else sum = sum + t;
        if (p > udiv64(Q60_ONE, nsq)) done = 1'b1;
        else p = p * nsq;
      end else begin
        done = 1'b1;
      end
    end
    return sum;
  endfunction

  function automatic longint unsigned atan_pow2_q60(input int i);
    longint unsigned sum, t;
    int ex;
    sum = 0;
    for (int k = 0; k < 64; k++) begin
      ex = 60 - i * (2 * k + 1);
      if (ex >= 0) begin
        t = udiv64(64'd1 << ex, longint'(2 * k + 1));
        if (k[0]) sum = sum - t;
        else sum = sum + t;
      end
    end
    return sum;
  endfunction

  function automatic logic [31:0] atan_turn(input int i);
    longint unsigned pi4, r;
    pi4 = 4 * atan_recip_q60(64'd5) - atan_recip_q60(64'd239);
    if (i == 0) r = 64'd1 << 29;
    else r = udiv64(atan_pow2_q60(i) << 3, pi4 >> 26);
    return r[31:0];
  endfunction

  function automatic logic [31:0] gain_inv_q30();
    longint unsigned gsq, r;
    gsq = Q60_ONE;
    for (int i = 0; i < CORDIC_STAGES; i++) gsq = gsq + (gsq >> (2 * i));
    r = udiv64(Q60_ONE, isqrt64(gsq));
    return r[31:0];
  endfunction

endpackage

FILE: hw/rtl/rope_if.sv
// Interfaces: input, output and configuration channels of the RoPE block.
interface rope_in_if;
  import rope_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [31:0]        x_first;
  logic signed [31:0]        x_second;
  logic [IDX_W-1:0]          pair_index;
  logic [POSITION_WIDTH-1:0] seq_position;
  logic                      last_pair;
  modport source (output valid, x_first, x_second, pair_index, seq_position, last_pair,
                  input ready);
  modport sink (input valid, x_first, x_second, pair_index, seq_position, last_pair,
                output ready);
endinterface

interface rope_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] y_first;
  logic signed [31:0] y_second;
  logic [1:0]         error_code;
  logic               last_out;
  modport source (output valid, y_first, y_second, error_code, last_out, input ready);
  modport sink (input valid, y_first, y_second, error_code, last_out, output ready);
endinterface

interface rope_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/rotary_position_embedding.sv
// Top level: rotary position embedding, one element pair per clock while data_out is not stalled.
//
// Usage: each request on data_in carries one pair (x_first, x_second, Q16.16)
// with its pair index and sequence position; data_out returns the rotated pair,
// an error code and a copy of last_pair, one result per request, in order.
// cfg writes pair_count (index 0), exponent_step (1) and the position base (2);
// other indexes are ignored. cfg is always ready; write it only while idle.
// Pipeline from accepted request to result valid: 2 input/exponent stages,
// 24 inverse-frequency multiply stages, 4 rate/angle stages, 1 fold,
// 24 CORDIC stages, 1 quadrant, 2 multiply/round stages, the last of which is
// the output register.
// Throughput: one pair per cycle while data_out does not stall; all stages advance together.
// Stall: when data_out is valid but not ready, the whole pipeline holds and
// data_in.ready drops in the same cycle; nothing is lost or duplicated.
// Reset (synchronous, active high) empties the pipeline and loads the register
// defaults: pair_count 64, exponent_step 3483196, position base 0.
module rotary_position_embedding (
  input  logic     clk,
  input  logic     rst,
  rope_in_if.sink  data_in,
  rope_out_if.source data_out,
  rope_cfg_if.sink cfg
);
  import rope_pkg::*;

  cfg_t  cfg_regs;
  logic  adv;
  logic  f_valid, c_valid;
  logic [31:0] turns;
  side_t f_side, c_side;
  logic signed [CS_W-1:0] cq, sq;

  assign cfg.ready     = 1'b1;
  assign adv           = !data_out.valid || data_out.ready;
  assign data_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.pair_count    <= PCNT_W'(64);
      cfg_regs.exponent_step <= STEP_W'(3483196);
      cfg_regs.pos_base      <= '0;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_PAIR_COUNT: cfg_regs.pair_count    <= cfg.data[PCNT_W-1:0];
        REG_EXP_STEP:   cfg_regs.exponent_step <= cfg.data[STEP_W-1:0];
        REG_POS_OFFSET: cfg_regs.pos_base      <= cfg.data[POSITION_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  rope_freq u_freq (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (data_in.valid),
    .x_first      (data_in.x_first),
    .x_second     (data_in.x_second),
    .pair_index   (data_in.pair_index),
    .seq_position (data_in.seq_position),
    .last_pair    (data_in.last_pair),
    .cfg          (cfg_regs),
    .out_valid    (f_valid),
    .turns        (turns),
    .out_side     (f_side)
  );

  rope_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .turns     (turns),
    .in_side   (f_side),
    .out_valid (c_valid),
    .cq        (cq),
    .sq        (sq),
    .out_side  (c_side)
  );

  rope_rotate u_rotate (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (c_valid),
    .cq         (cq),
    .sq         (sq),
    .in_side    (c_side),
    .out_valid  (data_out.valid),
    .y_first    (data_out.y_first),
    .y_second   (data_out.y_second),
    .error_code (data_out.error_code),
    .last_out   (data_out.last_out)
  );

endmodule

FILE: hw/rtl/rope_freq.sv
// Error check, inverse frequency pipeline and angle (turns) computation.
module rope_freq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic signed [31:0]                  x_first,
  input  logic signed [31:0]                  x_second,
  input  logic [rope_pkg::IDX_W-1:0]          pair_index,
  input  logic [rope_pkg::POSITION_WIDTH-1:0] seq_position,
  input  logic                                last_pair,
  input  rope_pkg::cfg_t                      cfg,
  output logic                                out_valid,
  output logic [31:0]                         turns,
  output rope_pkg::side_t                     out_side
);
  import rope_pkg::*;

  localparam int NR = FRAC_BITS;

  logic [PCNT_W-1:0]         limit;
  logic [POSITION_WIDTH:0]   pos_sum;
  err_t                      err_c;

  always_comb begin
    limit = (cfg.pair_count < PCNT_W'(MAX_PAIRS)) ? cfg.pair_count : PCNT_W'(MAX_PAIRS);
    pos_sum = {1'b0, cfg.pos_base} + {1'b0, seq_position};
    if ({1'b0, pair_index} >= limit) err_c = ERR_INDEX;
    else if (pos_sum[POSITION_WIDTH]) err_c = ERR_POS;
    else err_c = ERR_NONE;
  end

  // stage 0: inputs registered
  logic                      v0;
  side_t                     side0;
  logic [POSITION_WIDTH-1:0] pos0;
  logic [IDX_W-1:0]          idx0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (adv) v0 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      side0 <= '{a: x_first, b: x_second, err: err_c, last: last_pair};
      pos0  <= pos_sum[POSITION_WIDTH-1:0];
      idx0  <= pair_index;
    end
  end

  // root stages: rm[0] = 1.0 in Q.32 with the exponent product
  logic                      rv   [0:NR];
  side_t                     rside[0:NR];
  logic [POSITION_WIDTH-1:0] rpos [0:NR];
  logic [E_W-1:0]            re   [0:NR];
  logic [32:0]               rm   [0:NR];

  always_ff @(posedge clk) begin
    if (rst) rv[0] <= 1'b0;
    else if (adv) rv[0] <= v0;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      rside[0] <= side0;
      rpos[0]  <= pos0;
      re[0]    <= E_W'(idx0) * E_W'(cfg.exponent_step);
      rm[0]    <= 33'h1_0000_0000;
    end
  end

  for (genvar k = 0; k < NR; k++) begin : g_root
    localparam logic [31:0] ROOT = root_q32(k + 1);
    logic [64:0] prod;
    assign prod = 65'(rm[k]) * 65'(ROOT);
    always_ff @(posedge clk) begin
      if (rst) rv[k+1] <= 1'b0;
      else if (adv) rv[k+1] <= rv[k];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rside[k+1] <= rside[k];
        rpos[k+1]  <= rpos[k];
        re[k+1]    <= re[k];
        rm[k+1]    <= re[k][FRAC_BITS-1-k] ? prod[64:32] : rm[k];
      end
    end
  end

  // shift by integer part of the exponent
  logic [E_W-FRAC_BITS-1:0]  ipart;
  logic                      sv;
  side_t                     sside;
  logic [POSITION_WIDTH-1:0] spos;
  logic [32:0]               sm;

  assign ipart = re[NR][E_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) sv <= 1'b0;
    else if (adv) sv <= rv[NR];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sside <= rside[NR];
      spos  <= rpos[NR];
      sm    <= (|ipart[E_W-FRAC_BITS-1:6]) ? 33'd0 : (rm[NR] >> ipart[5:0]);
    end
  end

  // rate in turns per position, Q.64
  logic                      tv;
  side_t                     tside;
  logic [POSITION_WIDTH-1:0] tpos;
  logic [63:0]               rate;

  always_ff @(posedge clk) begin
    if (rst) tv <= 1'b0;
    else if (adv) tv <= sv;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      tside <= sside;
      tpos  <= spos;
      rate  <= 64'(sm) * 64'(INV_TWO_PI_Q32);
    end
  end

  // position times rate, split in two partial products
  logic                         pv;
  side_t                        pside;
  logic [POSITION_WIDTH+31:0]   plo;
  logic [31:0]                  phi;
  logic [POSITION_WIDTH+31:0]   phi_full;

  assign phi_full = (POSITION_WIDTH+32)'(tpos) * (POSITION_WIDTH+32)'(rate[63:32]);

  always_ff @(posedge clk) begin
    if (rst) pv <= 1'b0;
    else if (adv) pv <= tv;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      pside <= tside;
      plo   <= (POSITION_WIDTH+32)'(tpos) * (POSITION_WIDTH+32)'(rate[31:0]);
      phi   <= phi_full[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= pv;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_side <= pside;
      turns    <= phi + 32'(plo[POSITION_WIDTH+31:32]);
    end
  end

endmodule

FILE: hw/rtl/rope_cordic.sv
// Pipelined CORDIC: quadrant fold, rotation stages, quadrant restore.
module rope_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic [31:0]                         turns,
  input  rope_pkg::side_t                     in_side,
  output logic                                out_valid,
  output logic signed [rope_pkg::CS_W-1:0]    cq,
  output logic signed [rope_pkg::CS_W-1:0]    sq,
  output rope_pkg::side_t                     out_side
);
  import rope_pkg::*;

  localparam int N = CORDIC_STAGES;

  logic [31:0] shifted;
  logic [1:0]  q_c;
  logic [31:0] d_c;

  assign shifted = turns + 32'h2000_0000;
  assign q_c     = shifted[31:30];
  assign d_c     = turns - {q_c, 30'd0};

  logic                   cv   [0:N];
  side_t                  cside[0:N];
  logic [1:0]             cquad[0:N];
  logic signed [CS_W-1:0] cx   [0:N];
  logic signed [CS_W-1:0] cy   [0:N];
  logic signed [CS_W-1:0] cz   [0:N];

  always_ff @(posedge clk) begin
    if (rst) cv[0] <= 1'b0;
    else if (adv) cv[0] <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      cside[0] <= in_side;
      cquad[0] <= q_c;
      cx[0]    <= CS_W'(gain_inv_q30());
      cy[0]    <= '0;
      cz[0]    <= CS_W'(signed'(d_c));
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_rot
    localparam logic [31:0] ATAN = atan_turn(j);
    logic signed [CS_W-1:0] xs, ys;
    assign xs = cx[j] >>> j;
    assign ys = cy[j] >>> j;
    always_ff @(posedge clk) begin
      if (rst) cv[j+1] <= 1'b0;
      else if (adv) cv[j+1] <= cv[j];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cside[j+1] <= cside[j];
        cquad[j+1] <= cquad[j];
        if (!cz[j][CS_W-1]) begin
          cx[j+1] <= cx[j] - ys;
          cy[j+1] <= cy[j] + xs;
          cz[j+1] <= cz[j] - CS_W'(ATAN);
        end else begin
          cx[j+1] <= cx[j] + ys;
          cy[j+1] <= cy[j] - xs;
          cz[j+1] <= cz[j] + CS_W'(ATAN);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= cv[N];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_side <= cside[N];
      case (cquad[N])
        2'd0: begin cq <= cx[N];  sq <= cy[N];  end
        2'd1: begin cq <= -cy[N]; sq <= cx[N];  end
        2'd2: begin cq <= -cx[N]; sq <= -cy[N]; end
        default: begin cq <= cy[N]; sq <= -cx[N]; end
      endcase
    end
  end

endmodule

FILE: hw/rtl/rope_rotate.sv
// Rotation of the pair by cos/sin, rounding, saturation and output register; pairs with an error give zero.
module rope_rotate (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  logic                             in_valid,
  input  logic signed [rope_pkg::CS_W-1:0] cq,
  input  logic signed [rope_pkg::CS_W-1:0] sq,
  input  rope_pkg::side_t                  in_side,
  output logic                             out_valid,
  output logic signed [31:0]               y_first,
  output logic signed [31:0]               y_second,
  output logic [1:0]                       error_code,
  output logic                             last_out
);
  import rope_pkg::*;

  localparam int P_W = 32 + CS_W;
  localparam int S_W = P_W + 1;

  logic                  pv;
  side_t                 pside;
  logic signed [P_W-1:0] ac, bs, as_, bc;

  always_ff @(posedge clk) begin
    if (rst) pv <= 1'b0;
    else if (adv) pv <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      pside <= in_side;
      ac    <= P_W'(in_side.a) * P_W'(cq);
      bs    <= P_W'(in_side.b) * P_W'(sq);
      as_   <= P_W'(in_side.a) * P_W'(sq);
      bc    <= P_W'(in_side.b) * P_W'(cq);
    end
  end

  function automatic logic signed [31:0] round_sat(input logic signed [S_W-1:0] v);
    logic signed [S_W-1:0] r;
    r = (v + S_W'(64'sd1 << 29)) >>> 30;
    if (r > S_W'(64'sd2147483647)) return 32'sh7FFF_FFFF;
    else if (r < -S_W'(64'sd2147483648)) return 32'sh8000_0000;
    else return r[31:0];
  endfunction

  logic signed [S_W-1:0] sum0, sum1;
  assign sum0 = S_W'(ac) - S_W'(bs);
  assign sum1 = S_W'(as_) + S_W'(bc);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= pv;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      error_code <= pside.err;
      last_out   <= pside.last;
      if (pside.err != ERR_NONE) begin
        y_first  <= '0;
        y_second <= '0;
      end else begin
        y_first  <= round_sat(sum0);
        y_second <= round_sat(sum1);
      end
    end
  end

endmodule
